### sv/tbq_pkg.sv
// Shared types and constants of the timestamp bracket qualifier.
package tbq_pkg;

  localparam logic [63:0] NsPerSecond = 64'd1000000000;
  localparam logic [63:0] TscHzReset  = 64'd1000000000;
  localparam logic [15:0] AllowReset  = 16'd32;
  localparam logic [15:0] CountMax    = 16'hFFFF;
  localparam int unsigned DivSteps    = 64;

  typedef enum logic [0:0] {
    CFG_TSC_HZ    = 1'b0,
    CFG_ALLOWANCE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RSN_OK     = 2'd0,
    RSN_ORDER  = 2'd1,
    RSN_OVFL   = 2'd2,
    RSN_WINDOW = 2'd3
  } reason_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ROUND,
    ST_DIV,
    ST_JUDGE,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic take;     // latch the input word and the history
    logic prep;     // form the 128-bit product of span and one billion
    logic round;    // add hz - 1 and check the quotient range
    logic div_step; // one restoring step
    logic judge;    // decide and update statistics
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic judged;   // the word has two earlier pairs of its batch
    logic div_last; // final division step this cycle
  } sts_t;

endpackage

### sv/tbq_datapath.sv
// Datapath: pair history, 128-by-64 divider, checks and running statistics.
module tbq_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tbq_pkg::cmd_t        cmd_i,
  output tbq_pkg::sts_t        sts_o,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [63:0]          cfg_data_i,
  input  logic [63:0]          cpu_time_i,
  input  logic [63:0]          gpu_time_i,
  input  logic                 batch_start_i,
  input  logic [63:0]          window_low_i,
  input  logic [63:0]          window_high_i,
  output logic                 sample_ok_o,
  output logic [1:0]           reject_reason_o,
  output logic [63:0]          tick_mid_o,
  output logic [63:0]          tick_low_o,
  output logic [63:0]          tick_high_o,
  output logic [63:0]          device_ns_o,
  output logic [63:0]          bracket_ns_o,
  output logic                 regressed_o,
  output logic [15:0]          accepted_total_o,
  output logic [15:0]          rejected_total_o,
  output logic [63:0]          max_bracket_ns_o
);
  import tbq_pkg::*;

  logic [63:0] tsc_hz_q;
  logic [15:0] allow_q;
  logic [63:0] older_q, middle_q, mid_gpu_q;
  logic [1:0]  seen_q;
  logic [63:0] last_tick_q, last_ns_q, widest_q;
  logic        any_q;
  logic [15:0] acc_q, rej_q;

  // working copy of the word being judged
  logic [63:0] low_q, mid_q, high_q, dev_q, wlow_q, whigh_q, span_q;
  logic        judged_q;

  // divider
  logic [63:0] rem_q, lo_q, quo_q;
  logic        ovf_q;
  logic [5:0]  cnt_q;

  logic [1:0]  seen_eff;
  logic [95:0] p0, p1;
  logic [127:0] prod;
  logic [128:0] dvd;
  logic [64:0] rem_sh, rem_sub;
  logic [16:0] extra;
  logic [64:0] wsum;
  logic        bad_order, ovf_all, win_bad;
  reason_e     reason;

  assign seen_eff = batch_start_i ? 2'd0 : seen_q;

  // 32x30-bit partial products of span by one billion
  assign p0    = {32'd0, span_q[31:0]} * {32'd0, NsPerSecond};
  assign p1    = {32'd0, span_q[63:32]} * {32'd0, NsPerSecond};
  assign prod  = {32'd0, p0} + {p1, 32'd0};
  // round up: add hz - 1 before the floor division
  assign dvd   = {1'b0, rem_q, lo_q} + {65'd0, tsc_hz_q - 64'd1};

  assign rem_sh  = {rem_q, lo_q[63]};
  assign rem_sub = rem_sh - {1'b0, tsc_hz_q};

  assign extra     = {allow_q, 1'b0};
  assign wsum      = {1'b0, quo_q} + {48'd0, extra};
  assign bad_order = (low_q == 64'd0) || (mid_q == 64'd0) || (high_q == 64'd0) ||
                     (dev_q == 64'd0) || (low_q >= mid_q) || (mid_q >= high_q);
  assign ovf_all   = ovf_q || wsum[64];
  assign win_bad   = (low_q < wlow_q) || (high_q > whigh_q);

  always_comb begin
    if (bad_order)     reason = RSN_ORDER;
    else if (ovf_all)  reason = RSN_OVFL;
    else if (win_bad)  reason = RSN_WINDOW;
    else               reason = RSN_OK;
  end

  assign sts_o.judged   = judged_q;
  assign sts_o.div_last = (cnt_q == 6'(DivSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsc_hz_q    <= TscHzReset;
      allow_q     <= AllowReset;
      older_q     <= '0;
      middle_q    <= '0;
      mid_gpu_q   <= '0;
      seen_q      <= '0;
      last_tick_q <= '0;
      last_ns_q   <= '0;
      any_q       <= 1'b0;
      acc_q       <= '0;
      rej_q       <= '0;
      widest_q    <= '0;
      judged_q    <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_TSC_HZ:    tsc_hz_q <= cfg_data_i;
          CFG_ALLOWANCE: allow_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.take) begin
        judged_q  <= (seen_eff == 2'd2);
        older_q   <= middle_q;
        middle_q  <= cpu_time_i;
        mid_gpu_q <= gpu_time_i;
        seen_q    <= (seen_eff == 2'd2) ? 2'd2 : seen_eff + 2'd1;
      end
      if (cmd_i.prep) cnt_q <= '0;
      if (cmd_i.div_step) cnt_q <= cnt_q + 6'd1;
      if (cmd_i.judge) begin
        if (reason == RSN_OK) begin
          last_tick_q <= mid_q;
          last_ns_q   <= dev_q;
          any_q       <= 1'b1;
          if (wsum[63:0] > widest_q) widest_q <= wsum[63:0];
          if (acc_q != CountMax) acc_q <= acc_q + 16'd1;
        end else if (rej_q != CountMax) begin
          rej_q <= rej_q + 16'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      low_q   <= (seen_eff == 2'd2) ? older_q : '0;
      mid_q   <= middle_q;
      dev_q   <= mid_gpu_q;
      high_q  <= cpu_time_i;
      wlow_q  <= window_low_i;
      whigh_q <= window_high_i;
      span_q  <= cpu_time_i - older_q;
    end
    if (cmd_i.prep) begin
      rem_q <= prod[127:64];
      lo_q  <= prod[63:0];
      quo_q <= '0;
    end
    if (cmd_i.round) begin
      rem_q <= dvd[127:64];
      lo_q  <= dvd[63:0];
      ovf_q <= (tsc_hz_q == 64'd0) || dvd[128] || (dvd[127:64] >= tsc_hz_q);
    end
    if (cmd_i.div_step) begin
      lo_q <= {lo_q[62:0], 1'b0};
      if (!rem_sub[64]) begin
        rem_q <= rem_sub[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_sh[63:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
    if (cmd_i.judge) begin
      sample_ok_o     <= (reason == RSN_OK);
      reject_reason_o <= reason;
      tick_mid_o      <= mid_q;
      tick_low_o      <= low_q;
      tick_high_o     <= high_q;
      device_ns_o     <= dev_q;
      bracket_ns_o    <= (reason == RSN_OK) ? wsum[63:0] : '0;
      regressed_o     <= (reason == RSN_OK) && any_q &&
                         ((mid_q <= last_tick_q) || (dev_q <= last_ns_q));
      accepted_total_o <= (reason == RSN_OK && acc_q != CountMax) ? acc_q + 16'd1 : acc_q;
      rejected_total_o <= (reason != RSN_OK && rej_q != CountMax) ? rej_q + 16'd1 : rej_q;
      max_bracket_ns_o <= (reason == RSN_OK && wsum[63:0] > widest_q) ? wsum[63:0] : widest_q;
    end
  end

endmodule

### sv/tbq_ctrl.sv
// Controller: sequences take, divide, judge and result delivery.
module tbq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tbq_pkg::cmd_t cmd_o,
  input  tbq_pkg::sts_t sts_i
);
  import tbq_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PREP;
      ST_PREP:  state_d = sts_i.judged ? ST_ROUND : ST_IDLE;
      ST_ROUND: state_d = ST_DIV;
      ST_DIV:   if (sts_i.div_last) state_d = ST_JUDGE;
      ST_JUDGE: state_d = ST_OUT;
      ST_OUT:   if (!out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
      end
      ST_PREP:  cmd_o.prep = sts_i.judged;
      ST_ROUND: cmd_o.round = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_JUDGE: cmd_o.judge = 1'b1;
      ST_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

### sv/timestamp_bracket_qualifier.sv
// Top level of the timestamp bracket qualifier.
// One word at a time: a word that completes a bracket has its result valid after the
// steps form the product, round, 64 restoring divider steps and judge, with the
// one-bit-per-cycle 128-by-64 divider; the next word can be accepted in the cycle after
// the result is taken. A word without a result frees the input after passing through
// the prep state. Write configuration only while idle.
module timestamp_bracket_qualifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] cpu_time_i,
  input  logic [63:0] gpu_time_i,
  input  logic        batch_start_i,
  input  logic [63:0] window_low_i,
  input  logic [63:0] window_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        sample_ok_o,
  output logic [1:0]  reject_reason_o,
  output logic [63:0] tick_mid_o,
  output logic [63:0] tick_low_o,
  output logic [63:0] tick_high_o,
  output logic [63:0] device_ns_o,
  output logic [63:0] bracket_ns_o,
  output logic        regressed_o,
  output logic [15:0] accepted_total_o,
  output logic [15:0] rejected_total_o,
  output logic [63:0] max_bracket_ns_o
);
  import tbq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tbq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  tbq_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cpu_time_i, .gpu_time_i, .batch_start_i, .window_low_i, .window_high_i,
    .sample_ok_o, .reject_reason_o, .tick_mid_o, .tick_low_o, .tick_high_o,
    .device_ns_o, .bracket_ns_o, .regressed_o, .accepted_total_o,
    .rejected_total_o, .max_bracket_ns_o
  );

  a_ok_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_ok_o == (reject_reason_o == RSN_OK))) else $error("ok/reason");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during result");
  a_rej_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sample_ok_o) |-> (bracket_ns_o == 64'd0 && !regressed_o))
    else $error("rejected width");
  a_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sample_ok_o) |-> (max_bracket_ns_o >= bracket_ns_o)) else $error("max");

endmodule

### tb/tbq_checker.sv
// Checker for the timestamp bracket qualifier: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module tbq_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [63:0] cpu_time_i,
  input  logic [63:0] gpu_time_i,
  input  logic        batch_start_i,
  input  logic [63:0] window_low_i,
  input  logic [63:0] window_high_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        sample_ok_i,
  input  logic [1:0]  reject_reason_i,
  input  logic [63:0] tick_mid_i,
  input  logic [63:0] tick_low_i,
  input  logic [63:0] tick_high_i,
  input  logic [63:0] device_ns_i,
  input  logic [63:0] bracket_ns_i,
  input  logic        regressed_i,
  input  logic [15:0] accepted_total_i,
  input  logic [15:0] rejected_total_i,
  input  logic [63:0] max_bracket_ns_i,
  output int          errors_o,
  output int          pending_o
);
  import tbq_pkg::*;

  typedef struct packed {
    logic        ok;
    reason_e     reason;
    logic [63:0] mid;
    logic [63:0] low;
    logic [63:0] high;
    logic [63:0] dev;
    logic [63:0] width;
    logic        regr;
    logic [15:0] acc;
    logic [15:0] rej;
    logic [63:0] widest;
  } bracket_t;

  bracket_t    brackets_q[$];
  logic [63:0] hz;
  logic [15:0] allow;
  logic [63:0] older_tick, mid_tick, mid_ns, last_tick, last_ns, widest;
  logic [1:0]  seen;
  logic        any_acc;
  logic [15:0] acc_cnt, rej_cnt;

  assign pending_o = brackets_q.size();

  // ceil(span * 1e9 / hz) as a 128-bit quotient; overflow when it needs over 64 bits or hz is zero
  function automatic logic span_ns(input logic [63:0] span, output logic [63:0] ns);
    logic [127:0] num, quo;
    if (hz == '0) return 1'b0;
    num = 128'(span) * 128'(NsPerSecond) + 128'(hz) - 128'd1;
    quo = num / 128'(hz);
    ns  = quo[63:0];
    return quo[127:64] == '0;
  endfunction

  task automatic judge_word();
    bracket_t    b;
    logic [63:0] ns, extra;
    logic        fits;
    if (batch_start_i) seen = '0;
    if (seen == 2) begin
      b = '0;
      b.low = older_tick; b.mid = mid_tick; b.high = cpu_time_i; b.dev = mid_ns;
      extra = 64'(allow) * 2;
      fits = span_ns(cpu_time_i - older_tick, ns);
      if (older_tick == 0 || mid_tick == 0 || cpu_time_i == 0 || mid_ns == 0 ||
          older_tick >= mid_tick || mid_tick >= cpu_time_i)
        b.reason = RSN_ORDER;
      else if (!fits || ns > ~64'd0 - extra)
        b.reason = RSN_OVFL;
      else if (older_tick < window_low_i || cpu_time_i > window_high_i)
        b.reason = RSN_WINDOW;
      else
        b.reason = RSN_OK;
      if (b.reason == RSN_OK) begin
        b.width = ns + extra;
        b.regr = any_acc && (mid_tick <= last_tick || mid_ns <= last_ns);
        last_tick = mid_tick; last_ns = mid_ns; any_acc = 1'b1;
        if (b.width > widest) widest = b.width;
        if (acc_cnt != CountMax) acc_cnt++;
      end else if (rej_cnt != CountMax) begin
        rej_cnt++;
      end
      b.ok = b.reason == RSN_OK;
      b.acc = acc_cnt; b.rej = rej_cnt; b.widest = widest;
      brackets_q.push_back(b);
    end
    older_tick = mid_tick; mid_tick = cpu_time_i; mid_ns = gpu_time_i;
    if (seen < 2) seen++;
  endtask

  task automatic compare_word();
    bracket_t e;
    if (brackets_q.size() == 0) begin
      $error("unexpected result word");
      errors_o++;
      return;
    end
    e = brackets_q.pop_front();
    if (sample_ok_i !== e.ok) begin
      $error("sample_ok exp %0d got %0d", e.ok, sample_ok_i); errors_o++; end
    if (reject_reason_i !== e.reason) begin
      $error("reject_reason exp %0d got %0d", e.reason, reject_reason_i); errors_o++; end
    if (tick_mid_i !== e.mid) begin
      $error("tick_mid exp %0h got %0h", e.mid, tick_mid_i); errors_o++; end
    if (tick_low_i !== e.low) begin
      $error("tick_low exp %0h got %0h", e.low, tick_low_i); errors_o++; end
    if (tick_high_i !== e.high) begin
      $error("tick_high exp %0h got %0h", e.high, tick_high_i); errors_o++; end
    if (device_ns_i !== e.dev) begin
      $error("device_ns exp %0h got %0h", e.dev, device_ns_i); errors_o++; end
    if (bracket_ns_i !== e.width) begin
      $error("bracket_ns exp %0h got %0h", e.width, bracket_ns_i); errors_o++; end
    if (regressed_i !== e.regr) begin
      $error("regressed exp %0d got %0d", e.regr, regressed_i); errors_o++; end
    if (accepted_total_i !== e.acc) begin
      $error("accepted_total exp %0d got %0d", e.acc, accepted_total_i); errors_o++; end
    if (rejected_total_i !== e.rej) begin
      $error("rejected_total exp %0d got %0d", e.rej, rejected_total_i); errors_o++; end
    if (max_bracket_ns_i !== e.widest) begin
      $error("max_bracket_ns exp %0h got %0h", e.widest, max_bracket_ns_i); errors_o++; end
  endtask

  initial errors_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hz = TscHzReset; allow = AllowReset;
      older_tick = '0; mid_tick = '0; mid_ns = '0; seen = '0;
      last_tick = '0; last_ns = '0; any_acc = 1'b0;
      acc_cnt = '0; rej_cnt = '0; widest = '0;
      brackets_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TSC_HZ:    hz = cfg_data_i;
          CFG_ALLOWANCE: allow = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) compare_word();
      if (in_valid_i && !in_stall_i) judge_word();
    end
  end

endmodule

### tb/tb_timestamp_bracket_qualifier.sv
// Top of the timestamp bracket qualifier testbench: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb_timestamp_bracket_qualifier;
  import tbq_pkg::*;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_idx;
  logic [63:0] cfg_data;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [63:0] cpu_time, gpu_time, window_low, window_high;
  logic        batch_start;
  logic        sample_ok, regressed;
  logic [1:0]  reject_reason;
  logic [63:0] tick_mid, tick_low, tick_high, device_ns, bracket_ns, max_bracket_ns;
  logic [15:0] accepted_total, rejected_total;
  int          errors, pending;
  int          idle_pct;

  timestamp_bracket_qualifier u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cpu_time_i(cpu_time), .gpu_time_i(gpu_time), .batch_start_i(batch_start),
    .window_low_i(window_low), .window_high_i(window_high),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .sample_ok_o(sample_ok), .reject_reason_o(reject_reason),
    .tick_mid_o(tick_mid), .tick_low_o(tick_low), .tick_high_o(tick_high),
    .device_ns_o(device_ns), .bracket_ns_o(bracket_ns), .regressed_o(regressed),
    .accepted_total_o(accepted_total), .rejected_total_o(rejected_total),
    .max_bracket_ns_o(max_bracket_ns)
  );

  tbq_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .cpu_time_i(cpu_time), .gpu_time_i(gpu_time), .batch_start_i(batch_start),
    .window_low_i(window_low), .window_high_i(window_high),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .sample_ok_i(sample_ok), .reject_reason_i(reject_reason),
    .tick_mid_i(tick_mid), .tick_low_i(tick_low), .tick_high_i(tick_high),
    .device_ns_i(device_ns), .bracket_ns_i(bracket_ns), .regressed_i(regressed),
    .accepted_total_i(accepted_total), .rejected_total_i(rejected_total),
    .max_bracket_ns_i(max_bracket_ns),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // receiver stalls at random except during the quiet stretch
  always @(posedge clk) begin
    out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // valid stays high after acceptance; the next send or drain takes it down
  task automatic send(input logic [63:0] cpu, input logic [63:0] gpu, input logic start,
                      input logic [63:0] wlo, input logic [63:0] whi);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cpu_time <= cpu; gpu_time <= gpu; batch_start <= start;
    window_low <= wlo; window_high <= whi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop the input, wait for every expected result, then settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [63:0] val);
    drain();
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // a well-formed batch of increasing pairs, occasionally spoilt
  task automatic batch(input int n);
    logic [63:0] t, g, wlo, whi, step;
    int          k;
    step = 64'($urandom_range(1, ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : 5000));
    t = ($urandom_range(7) == 0) ? rand64() : 64'($urandom_range(1, 1000000));
    g = ($urandom_range(7) == 0) ? rand64() : 64'($urandom_range(1, 1000000));
    wlo = ($urandom_range(5) == 0) ? t + 64'($urandom_range(3)) : t - 64'($urandom_range(3));
    whi = ($urandom_range(5) == 0) ? t + step * n : ~64'd0;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(19))
        0: send(rand64(), rand64(), 1'b0, wlo, whi);
        1: send(t, 64'd0, 1'b0, wlo, whi);
        2: send(t - step, g, 1'b0, wlo, whi);
        default: send(t, g, k == 0, wlo, whi);
      endcase
      t = t + 64'($urandom_range(1, 2)) * step;
      g = g + 64'($urandom_range(0, 4000));
    end
  endtask

  initial begin
    int n;
    rst_n = 1'b0; in_valid = 1'b0; cfg_we = 1'b0; cfg_idx = CFG_TSC_HZ; cfg_data = '0;
    cpu_time = '0; gpu_time = '0; batch_start = 1'b0; window_low = '0; window_high = '0;
    out_stall = 1'b0; idle_pct = 30;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero stamps, order, window, overflow, extremes
    send(64'd10, 64'd5, 1'b1, 64'd0, ~64'd0);
    send(64'd20, 64'd6, 1'b0, 64'd0, ~64'd0);
    send(64'd30, 64'd7, 1'b0, 64'd0, ~64'd0);
    send(64'd25, 64'd8, 1'b0, 64'd0, ~64'd0);
    send(64'd0, 64'd0, 1'b0, 64'd0, ~64'd0);
    send(64'd40, 64'd9, 1'b1, 64'd0, ~64'd0);
    send(64'd50, 64'd0, 1'b0, 64'd0, ~64'd0);
    send(64'd60, 64'd9, 1'b0, 64'd45, ~64'd0);
    send(64'd70, 64'd10, 1'b0, 64'd0, 64'd65);
    send(64'd80, 64'd11, 1'b0, 64'd9, 64'd5);
    send(64'd1, 64'd1, 1'b1, 64'd0, ~64'd0);
    send(64'h8000_0000_0000_0000, ~64'd0, 1'b0, 64'd0, ~64'd0);
    send(~64'd0, 64'd2, 1'b0, 64'd0, ~64'd0);
    write_cfg(CFG_TSC_HZ, ~64'd0);
    write_cfg(CFG_ALLOWANCE, 64'hFFFF);
    send(64'd1, 64'd1, 1'b1, 64'd0, ~64'd0);
    send(64'd2, ~64'd0, 1'b0, 64'd0, ~64'd0);
    send(~64'd0, 64'd3, 1'b0, 64'd0, ~64'd0);
    send(~64'd0, 64'd4, 1'b0, 64'd0, ~64'd0);
    write_cfg(CFG_TSC_HZ, 64'd1);
    send(64'd5, 64'd1, 1'b1, 64'd0, ~64'd0);
    send(64'd6, 64'd2, 1'b0, 64'd0, ~64'd0);
    send(64'd7, 64'd3, 1'b0, 64'd0, ~64'd0);
    send(~64'd0, 64'd4, 1'b0, 64'd0, ~64'd0);
    write_cfg(CFG_TSC_HZ, 64'd0);
    write_cfg(CFG_ALLOWANCE, 64'd0);
    send(64'd5, 64'd1, 1'b1, 64'd0, ~64'd0);
    send(64'd6, 64'd2, 1'b0, 64'd0, ~64'd0);
    send(64'd7, 64'd3, 1'b0, 64'd0, ~64'd0);

    // random phases with differing settings
    n = 0;
    for (int ph = 0; n < 950; ph++) begin
      case (ph % 4)
        0: write_cfg(CFG_TSC_HZ, 64'd1000000000);
        1: write_cfg(CFG_TSC_HZ, 64'($urandom_range(1, 5000)));
        2: write_cfg(CFG_TSC_HZ, rand64());
        default: write_cfg(CFG_ALLOWANCE, 64'($urandom_range(65535)));
      endcase
      idle_pct = (ph == 3) ? 0 : 30;
      repeat (10) begin
        int len;
        len = $urandom_range(1, 12);
        if ($urandom_range(9) == 0) begin
          send(rand64(), rand64(), 1'($urandom_range(1)), rand64(), rand64());
          n += 1;
        end else begin
          batch(len);
          n += len;
        end
      end
    end

    idle_pct = 30;
    drain();
    if (errors == 0) $display("tb_timestamp_bracket_qualifier: PASS");
    else $display("tb_timestamp_bracket_qualifier: FAIL");
    $finish;
  end

  initial begin
    #1000000;
    $display("tb_timestamp_bracket_qualifier: FAIL");
    $finish;
  end

endmodule
